/* rtl/core/thc_pkg.sv */
`default_nettype none

package thc_pkg;

  // Field widths.
  localparam int unsigned RawTempW   = 20;
  localparam int unsigned RawHumW    = 16;
  localparam int unsigned ResultW    = 32;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 64;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 16;

  // Depth of the datapath, from the input register to the output register.
  localparam int unsigned NumStages  = 20;
  localparam int unsigned LastStage  = NumStages - 1;

  // Signed division by 100: |x| * ceil(2^37 / 100) >> 37 is exact for any 32-bit |x|.
  localparam logic [31:0] Div100Recip = 32'h51EB_851F;
  localparam int unsigned Div100Shift = 37;
  localparam int unsigned Div100QW    = 64 - Div100Shift;

  localparam logic [31:0] TempRound  = 32'd128;
  localparam logic [31:0] HumBias    = 32'd16384;
  localparam logic [31:0] HumScale   = 32'd1000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TEMP_COEF_ONE        = 3'd0,
    CFG_TEMP_COEF_TWO        = 3'd1,
    CFG_TEMP_COEF_THREE      = 3'd2,
    CFG_HUM_COEF_ONE         = 3'd3,
    CFG_HUM_COEF_TWO         = 3'd4,
    CFG_HUM_COEF_THREE_FOUR  = 3'd5,
    CFG_HUM_COEF_FIVE_SEVEN  = 3'd6,
    CFG_HUM_COEF_SIX         = 3'd7
  } cfg_idx_e;

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/thc_div100.sv */
`default_nettype none

// Three-stage signed divide by 100, truncating toward zero.
module thc_div100
  import thc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] dividend_i,
  output logic      [31:0] quotient_o
);

  logic                  neg_a_q, neg_b_q;
  logic [31:0]           mag_q;
  logic [63:0]           prod_q;
  logic [Div100QW-1:0]   quo_mag;
  logic [31:0]           quo_q;

  assign quo_mag = prod_q[63:Div100Shift];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= dividend_i[31];
      mag_q   <= dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
      neg_b_q <= neg_a_q;
      prod_q  <= 64'(mag_q) * 64'(Div100Recip);
      quo_q   <= neg_b_q ? (~32'(quo_mag) + 32'd1) : 32'(quo_mag);
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/temp_humidity_compensation_core.sv */
`default_nettype none

// Channel      Direction  Payload (lowest bits first)
// s_axis_*     in         raw_temperature[19:0], raw_humidity[35:20], zero pad to 40 bits
// m_axis_*     out        temperature_centi[31:0], humidity_milli[63:32]
// cfg_*        in         write enable, register index (0..7), 16-bit data
//
// One reading pair is taken per cycle while the output is not stalled; each result passes
// through the 20 register stages of the multiplier and divide chain.
// Reset clears the stage valid bits and the calibration registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.

module temp_humidity_compensation_core
  import thc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // raw_temperature[19:0], raw_humidity[35:20], zeros[39:36]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // temperature_centi[31:0], humidity_milli[63:32]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  // Calibration registers.
  logic [15:0] t1_q, t2_q, h34_q, h57_q;
  logic [7:0]  t3_q, h6_q;
  logic [11:0] h1_q, h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      h1_q  <= '0;
      h2_q  <= '0;
      h34_q <= '0;
      h57_q <= '0;
      h6_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TEMP_COEF_ONE:       t1_q  <= cfg_wdata_i;
        CFG_TEMP_COEF_TWO:       t2_q  <= cfg_wdata_i;
        CFG_TEMP_COEF_THREE:     t3_q  <= cfg_wdata_i[7:0];
        CFG_HUM_COEF_ONE:        h1_q  <= cfg_wdata_i[11:0];
        CFG_HUM_COEF_TWO:        h2_q  <= cfg_wdata_i[11:0];
        CFG_HUM_COEF_THREE_FOUR: h34_q <= cfg_wdata_i;
        CFG_HUM_COEF_FIVE_SEVEN: h57_q <= cfg_wdata_i;
        CFG_HUM_COEF_SIX:        h6_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Sign-extended coefficients.
  logic [31:0] t2_x, t3_x, h3_x, h4_x, h5_x, h7_x;
  assign t2_x = {{16{t2_q[15]}}, t2_q};
  assign t3_x = {{24{t3_q[7]}}, t3_q};
  assign h3_x = {{24{h34_q[7]}}, h34_q[7:0]};
  assign h4_x = {{24{h34_q[15]}}, h34_q[15:8]};
  assign h5_x = {{24{h57_q[7]}}, h57_q[7:0]};
  assign h7_x = {{24{h57_q[15]}}, h57_q[15:8]};

  // Handshake: every stage moves together whenever the output register is empty or being taken.
  logic                 adv;
  logic [LastStage:0]   vld_q;

  assign adv           = !vld_q[LastStage] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LastStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LastStage-1:0], s_axis_tvalid};
    end
  end

  // Datapath registers, named after the stage that loads them.
  logic [31:0] a_q;
  logic [15:0] hraw_q [0:7];
  logic [31:0] bp_q, ssq_q;
  logic [31:0] b_q, cp_q;
  logic [31:0] tc_q [3:LastStage];
  logic [31:0] m3_q, m4_q, m5_q, m7_q;
  logic [31:0] mt_q;
  logic [31:0] d1_q [8:13];
  logic [31:0] quad_q [8:15];
  logic [31:0] q4_q [8:11];
  logic [31:0] d2_q, gp_q;
  logic [31:0] prod_q [14:16];
  logic [31:0] sqp_q, cp2_q, sum_q, hk_q, hc_q;

  logic [31:0] q3, q4, q5, q7, q55;
  logic [31:0] fine, sa, p14;

  assign sa   = asr32(a_q, 5'd1);
  assign fine = b_q + asr32(cp_q, 5'd14);
  assign p14  = asr32(prod_q[14], 5'd14);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= 32'(s_axis_tdata[RawTempW-1:3]) - {15'd0, t1_q, 1'b0};
      hraw_q[0] <= s_axis_tdata[RawTempW +: RawHumW];
      for (int k = 1; k <= 7; k++) begin
        hraw_q[k] <= hraw_q[k-1];
      end

      bp_q      <= a_q * t2_x;
      ssq_q     <= sa * sa;

      b_q       <= asr32(bp_q, 5'd11);
      cp_q      <= asr32(ssq_q, 5'd12) * {t3_x[27:0], 4'd0};

      // Temperature: (fine * 5 + 128) >> 8.
      tc_q[3]   <= asr32(fine + {fine[29:0], 2'd0} + TempRound, 5'd8);
      for (int k = 4; k <= LastStage; k++) begin
        tc_q[k] <= tc_q[k-1];
      end

      m3_q      <= tc_q[3] * h3_x;
      m4_q      <= tc_q[3] * h4_x;
      m5_q      <= tc_q[3] * h5_x;
      m7_q      <= tc_q[3] * h7_x;

      mt_q      <= tc_q[7] * q5;
      d1_q[8]   <= 32'(hraw_q[7]) - {16'd0, h1_q, 4'd0} - asr32(q3, 5'd1);
      quad_q[8] <= asr32({17'd0, h6_q, 7'd0} + q7, 5'd4);
      q4_q[8]   <= q4;
      for (int k = 9; k <= 13; k++) begin
        d1_q[k] <= d1_q[k-1];
      end
      for (int k = 9; k <= 15; k++) begin
        quad_q[k] <= quad_q[k-1];
      end
      for (int k = 9; k <= 11; k++) begin
        q4_q[k] <= q4_q[k-1];
      end

      d2_q      <= q4_q[11] + q55 + HumBias;
      gp_q      <= {20'd0, h2_q} * d2_q;
      prod_q[14] <= d1_q[13] * asr32(gp_q, 5'd10);

      sqp_q      <= p14 * p14;
      prod_q[15] <= prod_q[14];

      cp2_q      <= quad_q[15] * asr32(sqp_q, 5'd10);
      prod_q[16] <= prod_q[15];

      sum_q     <= prod_q[16] + asr32(cp2_q, 5'd1);
      hk_q      <= asr32(sum_q, 5'd10) * HumScale;
      hc_q      <= asr32(hk_q, 5'd12);
    end
  end

  // The four coefficient products are divided side by side; the nested term follows.
  thc_div100 u_div_h3 (.clk_i(clk_i), .en_i(adv), .dividend_i(m3_q), .quotient_o(q3));
  thc_div100 u_div_h4 (.clk_i(clk_i), .en_i(adv), .dividend_i(m4_q), .quotient_o(q4));
  thc_div100 u_div_h5 (.clk_i(clk_i), .en_i(adv), .dividend_i(m5_q), .quotient_o(q5));
  thc_div100 u_div_h7 (.clk_i(clk_i), .en_i(adv), .dividend_i(m7_q), .quotient_o(q7));
  thc_div100 u_div_tt (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (asr32(mt_q, 5'd6)),
    .quotient_o (q55)
  );

  assign m_axis_tdata = {hc_q, tc_q[LastStage]};

endmodule

`default_nettype wire

/* rtl/core/thc_checker.sv */
`default_nettype none

module thc_checker
  import thc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // With no result waiting, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while no result is pending");

  // A taken result frees the pipeline, so the input side must be open too.
  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output is being accepted");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result presented on leaving reset");

  // A waiting result holds until its transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result changed or vanished");

endmodule

bind temp_humidity_compensation_core thc_checker u_thc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
